>>> rtl/mhpq_pkg.sv
package mhpq_pkg;
  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned KEY_BITS_DEF = 32;
  localparam int unsigned TAG_BITS_DEF = 16;
  localparam int unsigned POS_BITS = 10;
  localparam int unsigned CNT_BITS = 11;
  localparam int unsigned ST_BITS = 3;
  localparam int unsigned REQ_BITS = 2;

  localparam logic [REQ_BITS-1:0] REQ_ADD   = 2'd0;
  localparam logic [REQ_BITS-1:0] REQ_POP   = 2'd1;
  localparam logic [REQ_BITS-1:0] REQ_DEC   = 2'd2;
  localparam logic [REQ_BITS-1:0] REQ_CLEAR = 2'd3;

  localparam logic [ST_BITS-1:0] ST_OK    = 3'd0;
  localparam logic [ST_BITS-1:0] ST_FULL  = 3'd1;
  localparam logic [ST_BITS-1:0] ST_EMPTY = 3'd2;
  localparam logic [ST_BITS-1:0] ST_NOTAG = 3'd3;
  localparam logic [ST_BITS-1:0] ST_RAISE = 3'd4;
endpackage

>>> rtl/mhpq_req_if.sv
interface mhpq_req_if #(
  parameter int unsigned KEY_BITS = mhpq_pkg::KEY_BITS_DEF,
  parameter int unsigned TAG_BITS = mhpq_pkg::TAG_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [mhpq_pkg::REQ_BITS-1:0] req_type;
  logic [KEY_BITS-1:0]           key_in;
  logic [TAG_BITS-1:0]           payload_in;
  modport source (output valid, req_type, key_in, payload_in, input ready);
  modport sink (input valid, req_type, key_in, payload_in, output ready);
endinterface

>>> rtl/mhpq_rsp_if.sv
interface mhpq_rsp_if #(
  parameter int unsigned KEY_BITS = mhpq_pkg::KEY_BITS_DEF,
  parameter int unsigned TAG_BITS = mhpq_pkg::TAG_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [KEY_BITS-1:0]           key_out;
  logic [TAG_BITS-1:0]           payload_out;
  logic [mhpq_pkg::POS_BITS-1:0] position_out;
  logic [mhpq_pkg::ST_BITS-1:0]  status;
  logic [mhpq_pkg::CNT_BITS-1:0] count_out;
  modport source (output valid, key_out, payload_out, position_out, status, count_out,
                  input ready);
  modport sink (input valid, key_out, payload_out, position_out, status, count_out,
                output ready);
endinterface

>>> rtl/mhpq_store.sv
module mhpq_store #(
  parameter int unsigned DEPTH = mhpq_pkg::CAPACITY_DEF,
  parameter int unsigned WIDTH = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

>>> rtl/min_heap_priority_queue.sv
// Channel | Dir | Payload
// req     | in  | req_type, key_in, payload_in
// rsp     | out | key_out, payload_out, position_out, status, count_out
// One request at a time; one memory port read and one write per cycle.
// Add: the new entry is written at the end, then sifts up one level per UPRD, UPW, UPCMP pass.
// Pop: the last entry moves to the root, then sifts down one level per DNRD1..DNW2 pass.
// Decrease key: a linear search, through SRCH and SRW per entry, then sift up as add.
// Clear and flagged add or pop go straight to the response. Reset empties the heap at once.
// A stalled response holds; the next request is taken the cycle after it is taken.
module min_heap_priority_queue #(
  parameter int unsigned CAPACITY = mhpq_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_BITS = mhpq_pkg::KEY_BITS_DEF,
  parameter int unsigned TAG_BITS = mhpq_pkg::TAG_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  mhpq_req_if.sink   req,
  mhpq_rsp_if.source rsp
);
  import mhpq_pkg::*;
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned IW = AW + 1;
  localparam int unsigned EW = KEY_BITS + TAG_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_UPRD, S_UPW, S_UPCMP, S_DNRD1, S_DNW1, S_DNRD2, S_DNW2, S_DNCMP,
    S_SRCH, S_SRW, S_POPW, S_POPR, S_RESP
  } state_e;

  state_e state_q;
  logic [IW-1:0] cnt_q, pos_q, oth_q, pick_q;
  logic [KEY_BITS-1:0] key_q, pk_q, kc1_q;
  logic [TAG_BITS-1:0] tag_q, ptag_q, tc1_q;
  logic [REQ_BITS-1:0] req_q;
  logic [KEY_BITS-1:0] ko_q;
  logic [TAG_BITS-1:0] to_q;
  logic [POS_BITS-1:0] po_q;
  logic [ST_BITS-1:0]  st_q;
  logic rsp_v_q;

  logic we;
  logic [AW-1:0] wa, ra;
  logic [EW-1:0] wd, rd;
  logic [KEY_BITS-1:0] rk;
  logic [TAG_BITS-1:0] rt;
  assign rk = rd[EW-1:TAG_BITS];
  assign rt = rd[TAG_BITS-1:0];

  mhpq_store #(.DEPTH(CAPACITY), .WIDTH(EW)) u_store (
    .clk_i, .we_i(we), .waddr_i(wa), .wdata_i(wd), .raddr_i(ra), .rdata_o(rd)
  );

  logic [IW-1:0] parent, c1, c2;
  assign parent = (pos_q - IW'(1)) >> 1;
  assign c1 = {pos_q[IW-2:0], 1'b1};
  assign c2 = c1 + IW'(1);

  always_comb begin
    we = 1'b0;
    wa = pos_q[AW-1:0];
    wd = {key_q, tag_q};
    ra = parent[AW-1:0];
    case (state_q)
      S_IDLE:  ra = '0;
      S_UPRD:  begin we = 1'b1; ra = parent[AW-1:0]; end
      S_UPW:   ra = parent[AW-1:0];
      S_DNRD1: ra = c1[AW-1:0];
      S_DNW1:  ra = c2[AW-1:0];
      S_SRCH:  ra = pos_q[AW-1:0];
      S_POPR:  ra = cnt_q[AW-1:0];
      S_UPCMP: begin
        if (rk > key_q) begin
          we = 1'b1; wa = pos_q[AW-1:0]; wd = {rk, rt};
        end
      end
      S_DNCMP: begin
        if (key_q > pk_q) begin
          we = 1'b1; wa = pos_q[AW-1:0]; wd = {pk_q, ptag_q};
        end
      end
      S_SRW:   begin
        we = (req_q != REQ_DEC) || ((rt == tag_q) && !(key_q > rk));
        wd = {key_q, tag_q};
      end
      S_POPW:  begin we = 1'b1; wd = {rk, rt}; end
      S_DNW2:  we = 1'b1;
      default: ;
    endcase
  end

  assign req.ready = (state_q == S_IDLE) && !rsp_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      rsp_v_q <= 1'b0;
    end else begin
      if (rsp_v_q && rsp.ready) rsp_v_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            req_q <= req.req_type;
            key_q <= req.key_in;
            tag_q <= req.payload_in;
            ko_q <= '0; to_q <= '0; po_q <= '0; st_q <= ST_OK;
            case (req.req_type)
              REQ_ADD: begin
                if (cnt_q >= IW'(CAPACITY)) begin
                  st_q <= ST_FULL; state_q <= S_RESP;
                end else begin
                  pos_q <= cnt_q; cnt_q <= cnt_q + IW'(1); state_q <= S_SRW;
                end
              end
              REQ_POP: begin
                if (cnt_q == '0) begin
                  st_q <= ST_EMPTY; state_q <= S_RESP;
                end else begin
                  pos_q <= '0; cnt_q <= cnt_q - IW'(1); state_q <= S_POPR;
                end
              end
              REQ_DEC: begin pos_q <= '0; state_q <= S_SRCH; end
              default: begin cnt_q <= '0; state_q <= S_RESP; end
            endcase
          end
        end
        S_SRCH: begin
          if (pos_q >= cnt_q) begin
            st_q <= ST_NOTAG; state_q <= S_RESP;
          end else begin
            state_q <= S_SRW;
            oth_q <= pos_q;
          end
        end
        S_SRW: begin
          if (req_q == REQ_DEC && rt != tag_q) begin
            pos_q <= oth_q + IW'(1); state_q <= S_SRCH;
          end else if (req_q == REQ_DEC && key_q > rk) begin
            st_q <= ST_RAISE; state_q <= S_RESP;
          end else begin
            if (req_q == REQ_DEC) pos_q <= oth_q;
            state_q <= S_UPRD;
          end
        end
        S_UPRD: begin
          if (pos_q == '0) state_q <= S_RESP;
          else state_q <= S_UPW;
        end
        S_UPW: state_q <= S_UPCMP;
        S_UPCMP: begin
          if (rk > key_q) begin
            pos_q <= parent; state_q <= S_UPRD;
          end else state_q <= S_RESP;
        end
        S_POPR: state_q <= S_POPW;
        S_POPW: state_q <= S_DNRD1;
        S_DNRD1: state_q <= S_DNW1;
        S_DNW1: begin kc1_q <= rk; tc1_q <= rt; state_q <= S_DNRD2; end
        S_DNRD2: begin
          if (c1 >= cnt_q) state_q <= S_RESP;
          else begin
            pick_q <= c1; pk_q <= kc1_q; ptag_q <= tc1_q;
            if (c2 < cnt_q && rk < kc1_q) begin
              pick_q <= c2; pk_q <= rk; ptag_q <= rt;
            end
            state_q <= S_DNCMP;
          end
        end
        S_DNCMP: begin
          if (key_q > pk_q) begin pos_q <= pick_q; state_q <= S_DNW2; end
          else state_q <= S_RESP;
        end
        S_DNW2: state_q <= S_DNRD1;
        S_RESP: begin
          if (req_q == REQ_DEC && st_q == ST_OK) po_q <= POS_BITS'(pos_q);
          rsp_v_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
      if (state_q == S_POPR) begin ko_q <= rk; to_q <= rt; end
      if (state_q == S_POPW) begin key_q <= rk; tag_q <= rt; end
    end
  end

  assign rsp.valid        = rsp_v_q;
  assign rsp.key_out      = ko_q;
  assign rsp.payload_out  = to_q;
  assign rsp.position_out = po_q;
  assign rsp.status       = st_q;
  assign rsp.count_out    = CNT_BITS'(cnt_q);

  assert property (@(posedge clk_i) disable iff (!rst_ni) rsp_v_q |-> state_q == S_IDLE)
    else $error("response while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= IW'(CAPACITY))
    else $error("count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP) |=> rsp_v_q) else $error("response lost");
endmodule
